### rtl/ftc_pkg.sv
// Shared types, codes and helpers of the floor and ceiling texture caster.
`timescale 1ns / 1ps

package ftc_pkg;

  // Input item modes and texture selects
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_RENDER = 1'b1;
  localparam logic TEX_FLOOR   = 1'b0;
  localparam logic TEX_CEIL    = 1'b1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_POS_X   = 3'd0,
    CFG_POS_Y   = 3'd1,
    CFG_LEFT_X  = 3'd2,
    CFG_LEFT_Y  = 3'd3,
    CFG_RIGHT_X = 3'd4,
    CFG_RIGHT_Y = 3'd5,
    CFG_WIDTH   = 3'd6,
    CFG_HEIGHT  = 3'd7
  } cfg_idx_e;

  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;

  // Fixed-point widths
  localparam int RAY_W   = 29;  // left*W + (right-left)*col
  localparam int DIST_W  = 27;  // (H << 15) / p
  localparam int DIST_SH = 15;
  localparam int DLO_W   = 14;  // low slice of the distance for the split multiply
  localparam int T_W     = 44;  // (dist * ray) >> 14
  localparam int RAY_SH  = 14;

  typedef struct packed {
    logic        is_wr;
    logic        choice;
    logic [11:0] addr;
    logic [31:0] word;
    logic [10:0] col;
    logic [10:0] row;
    logic [10:0] crow;
  } item_t;

  typedef struct packed {
    item_t                   item;
    logic signed [RAY_W-1:0] rx;
    logic signed [RAY_W-1:0] ry;
  } dist_pay_t;

  typedef struct packed {
    item_t item;
    logic  neg;
  } off_pay_t;

  // RGBA in, ARGB out with the colour channels halved
  function automatic logic [31:0] shade(input logic [31:0] px);
    shade = {px[7:0], 1'b0, px[31:25], 1'b0, px[23:17], 1'b0, px[15:9]};
  endfunction

endpackage

### rtl/ftc_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with payload.
`timescale 1ns / 1ps

module ftc_divider #(
  parameter int NumW = 27,
  parameter int DenW = 11,
  parameter int PayW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [PayW-1:0] pay_i,
  output logic            valid_o,
  output logic [NumW-1:0] quo_o,
  output logic [DenW-1:0] rem_o,
  output logic [PayW-1:0] pay_o
);

  logic            valid_q [NumW];
  logic [NumW-1:0] nq_q    [NumW];
  logic [DenW-1:0] rem_q   [NumW];
  logic [DenW-1:0] den_q   [NumW];
  logic [PayW-1:0] pay_q   [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic            v_in;
    logic [NumW-1:0] nq_in;
    logic [DenW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [PayW-1:0] pay_in;
    logic [DenW:0]   trial;
    logic [DenW:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign nq_in  = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
      assign pay_in = pay_i;
    end else begin : g_next
      assign v_in   = valid_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign pay_in = pay_q[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign trial = {rem_in, nq_in[NumW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k]  <= {nq_in[NumW-2:0], ge};
        rem_q[k] <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
        den_q[k] <= den_in;
        pay_q[k] <= pay_in;
      end
    end
  end

  assign valid_o = valid_q[NumW-1];
  assign quo_o   = nq_q[NumW-1];
  assign rem_o   = rem_q[NumW-1];
  assign pay_o   = pay_q[NumW-1];

endmodule

### rtl/ftc_texture.sv
// Floor and ceiling texture memories, one write and two registered reads.
`timescale 1ns / 1ps

module ftc_texture import ftc_pkg::*; #(
  parameter int AddrW = 12
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             wr_en_i,
  input  logic             wr_sel_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [31:0]      wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [31:0]      floor_data_o,
  output logic [31:0]      ceil_data_o
);

  logic [31:0] floor_mem [2**AddrW];
  logic [31:0] ceil_mem  [2**AddrW];
  logic [31:0] floor_rd_q;
  logic [31:0] ceil_rd_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (wr_en_i && (wr_sel_i == TEX_FLOOR)) begin
        floor_mem[wr_addr_i] <= wr_data_i;
      end
      floor_rd_q <= floor_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (wr_en_i && (wr_sel_i == TEX_CEIL)) begin
        ceil_mem[wr_addr_i] <= wr_data_i;
      end
      ceil_rd_q <= ceil_mem[rd_addr_i];
    end
  end

  assign floor_data_o = floor_rd_q;
  assign ceil_data_o  = ceil_rd_q;

endmodule

### rtl/floor_ceiling_texture_caster_core.sv
// Top level of the floor and ceiling texture caster pixel pipeline.
//
// Takes one request per clock and returns one floor/ceiling pixel pair per clock
// for every render request whose row lies in the lower screen half; texture
// writes and rows outside that half produce nothing. A request passes through
// the pipeline: two front stages, a 27-stage distance divider, three
// multiply/shift stages, a 44-stage offset divider (one per axis, side by side),
// one texel-index stage and the registered texture read, which is also the
// output stage. Each divider stage resolves one quotient bit. Texture writes
// travel the same pipeline and land in memory at the read stage, so reads and
// writes take effect in request order. The texture memories are not cleared:
// render only texels that were written. When a result is stalled at the output
// the whole pipeline holds and no request is taken; configure only while idle.
`timescale 1ns / 1ps

module floor_ceiling_texture_caster_core import ftc_pkg::*; #(
  parameter int TEX_SIZE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic        texture_choice_i,
  input  logic [11:0] texel_address_i,
  input  logic [31:0] texel_word_i,
  input  logic [10:0] pixel_column_i,
  input  logic [10:0] pixel_row_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] out_column_o,
  output logic [10:0] floor_row_o,
  output logic [10:0] ceiling_row_o,
  output logic [31:0] floor_argb_o,
  output logic [31:0] ceil_argb_o
);

  localparam int TexL  = $clog2(TEX_SIZE);
  localparam int TexAw = 2 * TexL;

  // ---------------------------------------------------------------- config
  logic [23:0]       pos_x_q, pos_y_q;
  logic signed [15:0] left_x_q, left_y_q, right_x_q, right_y_q;
  logic [11:0]       width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      left_x_q  <= '0;
      left_y_q  <= '0;
      right_x_q <= '0;
      right_y_q <= '0;
      width_q   <= WIDTH_RESET;
      height_q  <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_POS_X:   pos_x_q   <= cfg_data_i;
        CFG_POS_Y:   pos_y_q   <= cfg_data_i;
        CFG_LEFT_X:  left_x_q  <= cfg_data_i[15:0];
        CFG_LEFT_Y:  left_y_q  <= cfg_data_i[15:0];
        CFG_RIGHT_X: right_x_q <= cfg_data_i[15:0];
        CFG_RIGHT_Y: right_y_q <= cfg_data_i[15:0];
        CFG_WIDTH:   width_q   <= cfg_data_i[11:0];
        CFG_HEIGHT:  height_q  <= cfg_data_i[11:0];
      endcase
    end
  end

  // a zero width behaves as one
  logic [11:0] w_eff;
  assign w_eff = (width_q == '0) ? 12'd1 : width_q;

  // ---------------------------------------------------------------- flow
  // One enable for every stage: advance unless a finished result is stalled.
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // ---------------------------------------------------------------- stage A
  // Register the request, check the row and form p = row - half.
  logic [10:0] half;
  logic        row_ok;
  logic [11:0] crow_full;
  item_t       a_item_d;

  assign half      = height_q[11:1];
  assign row_ok    = (pixel_row_i > half) && ({1'b0, pixel_row_i} < height_q);
  assign crow_full = height_q - {1'b0, pixel_row_i} - 12'd1;

  always_comb begin
    a_item_d.is_wr  = (mode_i == MODE_WRITE);
    a_item_d.choice = texture_choice_i;
    a_item_d.addr   = texel_address_i;
    a_item_d.word   = texel_word_i;
    a_item_d.col    = pixel_column_i;
    a_item_d.row    = pixel_row_i;
    a_item_d.crow   = crow_full[10:0];
  end

  logic        a_valid_q;
  item_t       a_item_q;
  logic [10:0] a_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      // drop render requests outside the lower half right here
      a_valid_q <= in_valid_i && ((mode_i == MODE_WRITE) || row_ok);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_item_q <= a_item_d;
      a_p_q    <= pixel_row_i - half;
    end
  end

  // ---------------------------------------------------------------- stage B
  // Ray numerators: left*W and (right-left)*column, per axis.
  logic signed [RAY_W-1:0] lw_x, lw_y, dc_x, dc_y;
  logic signed [RAY_W-1:0] w_s, col_s;

  assign w_s   = RAY_W'($signed({1'b0, w_eff}));
  assign col_s = RAY_W'($signed({1'b0, a_item_q.col}));
  assign lw_x  = RAY_W'(left_x_q) * w_s;
  assign lw_y  = RAY_W'(left_y_q) * w_s;
  assign dc_x  = (RAY_W'(right_x_q) - RAY_W'(left_x_q)) * col_s;
  assign dc_y  = (RAY_W'(right_y_q) - RAY_W'(left_y_q)) * col_s;

  logic                    b_valid_q;
  item_t                   b_item_q;
  logic [10:0]             b_p_q;
  logic signed [RAY_W-1:0] b_lw_x_q, b_lw_y_q, b_dc_x_q, b_dc_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_item_q <= a_item_q;
      b_p_q    <= a_p_q;
      b_lw_x_q <= lw_x;
      b_lw_y_q <= lw_y;
      b_dc_x_q <= dc_x;
      b_dc_y_q <= dc_y;
    end
  end

  // ---------------------------------------------------------------- distance
  // Row distance = (H << 15) / p, Q12.15; the ray sums ride along as payload.
  dist_pay_t          dist_pay_in, dist_pay_out;
  logic               dist_valid;
  logic [DIST_W-1:0]  dist_quo;
  logic [10:0]        dist_rem;

  always_comb begin
    dist_pay_in.item = b_item_q;
    dist_pay_in.rx   = b_lw_x_q + b_dc_x_q;
    dist_pay_in.ry   = b_lw_y_q + b_dc_y_q;
  end

  ftc_divider #(
    .NumW (DIST_W),
    .DenW (11),
    .PayW ($bits(dist_pay_t))
  ) u_dist_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_valid_q),
    .num_i   ({height_q, {DIST_SH{1'b0}}}),
    .den_i   (b_p_q),
    .pay_i   (dist_pay_in),
    .valid_o (dist_valid),
    .quo_o   (dist_quo),
    .rem_o   (dist_rem),
    .pay_o   (dist_pay_out)
  );

  // ---------------------------------------------------------------- stage D
  // Split multiply distance * ray into a low and a high slice of the distance.
  localparam int P0W = RAY_W + DLO_W + 1;
  localparam int P1W = RAY_W + DIST_W - DLO_W + 1;

  logic signed [P0W-1:0] dlo_s;
  logic signed [P1W-1:0] dhi_s;

  assign dlo_s = P0W'($signed({1'b0, dist_quo[DLO_W-1:0]}));
  assign dhi_s = P1W'($signed({1'b0, dist_quo[DIST_W-1:DLO_W]}));

  logic                  d_valid_q;
  item_t                 d_item_q;
  logic signed [P0W-1:0] d_p0_x_q, d_p0_y_q;
  logic signed [P1W-1:0] d_p1_x_q, d_p1_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (en) begin
      d_valid_q <= dist_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_item_q <= dist_pay_out.item;
      d_p0_x_q <= P0W'(dist_pay_out.rx) * dlo_s;
      d_p0_y_q <= P0W'(dist_pay_out.ry) * dlo_s;
      d_p1_x_q <= P1W'(dist_pay_out.rx) * dhi_s;
      d_p1_y_q <= P1W'(dist_pay_out.ry) * dhi_s;
    end
  end

  // ---------------------------------------------------------------- stage E
  // t = floor(distance*ray / 2^14) = p1 + floor(p0 / 2^14), since the high
  // slice already carries the 2^14 weight.
  logic                  e_valid_q;
  item_t                 e_item_q;
  logic signed [T_W-1:0] e_t_x_q, e_t_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (en) begin
      e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_item_q <= d_item_q;
      e_t_x_q  <= T_W'(d_p1_x_q) + T_W'(d_p0_x_q >>> RAY_SH);
      e_t_y_q  <= T_W'(d_p1_y_q) + T_W'(d_p0_y_q >>> RAY_SH);
    end
  end

  // ---------------------------------------------------------------- stage F
  // Sign and magnitude for the floor division by the width.
  logic             f_valid_q;
  item_t            f_item_q;
  logic             f_neg_x_q, f_neg_y_q;
  logic [T_W-1:0]   f_mag_x_q, f_mag_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_item_q  <= e_item_q;
      f_neg_x_q <= e_t_x_q[T_W-1];
      f_neg_y_q <= e_t_y_q[T_W-1];
      f_mag_x_q <= e_t_x_q[T_W-1] ? T_W'(-e_t_x_q) : T_W'(e_t_x_q);
      f_mag_y_q <= e_t_y_q[T_W-1] ? T_W'(-e_t_y_q) : T_W'(e_t_y_q);
    end
  end

  // ---------------------------------------------------------------- offset
  off_pay_t        offx_pay_in, offx_pay_out;
  logic            offx_valid, offy_valid;
  logic [T_W-1:0]  offx_quo, offy_quo;
  logic [11:0]     offx_rem, offy_rem;
  logic            offy_neg;

  always_comb begin
    offx_pay_in.item = f_item_q;
    offx_pay_in.neg  = f_neg_x_q;
  end

  ftc_divider #(
    .NumW (T_W),
    .DenW (12),
    .PayW ($bits(off_pay_t))
  ) u_offx_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid_q),
    .num_i   (f_mag_x_q),
    .den_i   (w_eff),
    .pay_i   (offx_pay_in),
    .valid_o (offx_valid),
    .quo_o   (offx_quo),
    .rem_o   (offx_rem),
    .pay_o   (offx_pay_out)
  );

  ftc_divider #(
    .NumW (T_W),
    .DenW (12),
    .PayW (1)
  ) u_offy_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid_q),
    .num_i   (f_mag_y_q),
    .den_i   (w_eff),
    .pay_i   (f_neg_y_q),
    .valid_o (offy_valid),
    .quo_o   (offy_quo),
    .rem_o   (offy_rem),
    .pay_o   (offy_neg)
  );

  // ---------------------------------------------------------------- stage G
  // Restore the sign with floor rounding: -(q + (r != 0)) is ~q when the
  // remainder is nonzero, ~q + 1 otherwise. Only the low 16 bits matter.
  logic [15:0] off_x16, off_y16, world_x16, world_y16;

  assign off_x16   = offx_pay_out.neg ? (~offx_quo[15:0] + 16'(offx_rem == '0))
                                      : offx_quo[15:0];
  assign off_y16   = offy_neg ? (~offy_quo[15:0] + 16'(offy_rem == '0))
                              : offy_quo[15:0];
  assign world_x16 = pos_x_q[15:0] + off_x16;
  assign world_y16 = pos_y_q[15:0] + off_y16;

  logic             g_valid_q;
  item_t            g_item_q;
  logic [TexAw-1:0] g_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_valid_q <= 1'b0;
    end else if (en) begin
      g_valid_q <= offx_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_item_q <= offx_pay_out.item;
      g_idx_q  <= {world_y16[15:16-TexL], world_x16[15:16-TexL]};
    end
  end

  // ---------------------------------------------------------------- texture
  // Write requests land here; render requests read both textures.
  logic [15:0]      wr_addr_ext;
  logic [31:0]      floor_data, ceil_data;

  assign wr_addr_ext = {4'b0, g_item_q.addr};

  ftc_texture #(
    .AddrW (TexAw)
  ) u_texture (
    .clk_i        (clk_i),
    .en_i         (en),
    .wr_en_i      (g_valid_q && g_item_q.is_wr),
    .wr_sel_i     (g_item_q.choice),
    .wr_addr_i    (wr_addr_ext[TexAw-1:0]),
    .wr_data_i    (g_item_q.word),
    .rd_addr_i    (g_idx_q),
    .floor_data_o (floor_data),
    .ceil_data_o  (ceil_data)
  );

  // ---------------------------------------------------------------- output
  logic [10:0] out_col_q, out_row_q, out_crow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= g_valid_q && !g_item_q.is_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_col_q  <= g_item_q.col;
      out_row_q  <= g_item_q.row;
      out_crow_q <= g_item_q.crow;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_column_o  = out_col_q;
  assign floor_row_o   = out_row_q;
  assign ceiling_row_o = out_crow_q;
  assign floor_argb_o  = shade(floor_data);
  assign ceil_argb_o   = shade(ceil_data);

  // ---------------------------------------------------------------- checks
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(a_valid_q))
    else $error("front stage moved while the pipeline was held");

  a_p_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !a_item_q.is_wr |-> a_p_q != '0)
    else $error("render request entered the divider with a zero row offset");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    offx_valid == offy_valid)
    else $error("offset dividers out of step");

  a_render_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && g_valid_q && !g_item_q.is_wr |=> out_valid_q)
    else $error("render request lost at the texture stage");

  a_write_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && g_valid_q && g_item_q.is_wr |=> !out_valid_q)
    else $error("texture write produced a result");

endmodule
